// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files; dwpid_merge includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dwpid_pkg.sv -----
package dwpid_pkg;

  localparam logic [9:0]  FULL_SCALE    = 10'd900;
  localparam logic [9:0]  LIMIT_RESET   = 10'd300;
  localparam logic [15:0] KP_RESET      = 16'd1280;
  localparam logic [15:0] KI_RESET      = 16'd512;
  localparam logic [15:0] KD_RESET      = 16'd128;
  localparam logic [7:0]  DEAD_RESET    = 8'd5;

  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LEFT_KP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_KI     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_KD     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_KP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_KI    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_KD    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEAD_OFFSET = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_CAP   = 3'd7;

  // Load strobes for the four lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  // What one lane hands to the output register.
  typedef struct packed {
    logic [9:0]         pulse;
    logic               reverse;
    logic signed [23:0] command;
  } lane_res_t;

endpackage

// ----- rtl/dwpid_lane.sv -----
module dwpid_lane
  import dwpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  adv_t               adv,
  input  logic signed [15:0] count,
  input  logic signed [15:0] target,
  input  logic [15:0]        kp,
  input  logic [15:0]        ki,
  input  logic [15:0]        kd,
  input  logic [7:0]         dead_offset,
  input  logic [9:0]         drive_cap,
  output lane_res_t          res
);

  // Controller state.
  logic signed [31:0] integral_r, integral_nxt;
  logic signed [16:0] prev_r;

  // Stage 1: error and error difference.
  logic signed [16:0] err_nxt;
  logic signed [16:0] err_r;
  logic signed [17:0] diff_r;

  // Stage 2: gain products (Q.8).
  logic signed [32:0] pk_r, pi_r;
  logic signed [33:0] pd_r;
  logic signed [32:0] pk_full, pi_full;
  logic signed [33:0] pd_full;

  // Stage 3: integral update and pass-through of the P and D terms.
  logic signed [32:0] pk3_r;
  logic signed [33:0] pd3_r;
  logic signed [33:0] isum;

  // Stage 4: truncated command.
  logic signed [34:0] sum;
  logic signed [34:0] biased;
  logic signed [26:0] cmd_nxt, cmd_r;

  // Output shaping.
  logic [9:0]         top;
  logic signed [26:0] top_s, lim_s;
  logic signed [10:0] c1, c2, mag;
  logic               neg;
  logic signed [23:0] cmd_sat;

  assign err_nxt = 17'(target) - 17'(count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (adv.s1) begin
      prev_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      err_r  <= err_nxt;
      diff_r <= 18'(err_nxt) - 18'(prev_r);
    end
  end

  assign pk_full = 33'(err_r) * $signed({17'd0, kp});
  assign pi_full = 33'(err_r) * $signed({17'd0, ki});
  assign pd_full = 34'(diff_r) * $signed({18'd0, kd});

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pk_r <= pk_full;
      pi_r <= pi_full;
      pd_r <= pd_full;
    end
  end

  // Saturating integral update.
  assign isum = 34'(integral_r) + 34'(pi_r);

  always_comb begin
    if (isum[33:31] == 3'b000 || isum[33:31] == 3'b111) begin
      integral_nxt = isum[31:0];
    end else if (isum[33]) begin
      integral_nxt = 32'sh8000_0000;
    end else begin
      integral_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
    end else if (adv.s3) begin
      integral_r <= integral_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pk3_r <= pk_r;
      pd3_r <= pd_r;
    end
  end

  // The integral register only moves when stage 3 loads, together with the
  // stage 3 registers, so it always matches the item held in stage 3.
  assign sum     = 35'(pk3_r) + 35'(integral_r) + 35'(pd3_r);
  assign biased  = sum + (sum[34] ? 35'sd255 : 35'sd0);
  assign cmd_nxt = biased[34:8];

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign top   = FULL_SCALE - {2'b00, dead_offset};
  assign top_s = $signed({17'd0, top});
  assign lim_s = $signed({17'd0, drive_cap});

  always_comb begin
    if (cmd_r >= top_s) begin
      c1 = top_s[10:0];
    end else if (cmd_r < -top_s) begin
      c1 = 11'(-top_s);
    end else begin
      c1 = cmd_r[10:0];
    end
    if (27'(c1) > lim_s) begin
      c2 = lim_s[10:0];
    end else if (27'(c1) < -lim_s) begin
      c2 = 11'(-lim_s);
    end else begin
      c2 = c1;
    end
    neg = c2[10];
    mag = neg ? -c2 : c2;
  end

  always_comb begin
    if (cmd_r[26:23] == 4'b0000 || cmd_r[26:23] == 4'b1111) begin
      cmd_sat = cmd_r[23:0];
    end else if (cmd_r[26]) begin
      cmd_sat = 24'sh80_0000;
    end else begin
      cmd_sat = 24'sh7f_ffff;
    end
  end

  assign res = '{pulse: mag[9:0] + {2'b00, dead_offset}, reverse: neg, command: cmd_sat};

endmodule

// ----- rtl/dwpid_merge.sv -----
module dwpid_merge
  import dwpid_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output adv_t         adv,
  input  lane_res_t    left_res,
  input  lane_res_t    right_res,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [9:0]   out_left_pulse,
  output logic         out_left_reverse,
  output logic [9:0]   out_right_pulse,
  output logic         out_right_reverse,
  output logic [23:0]  out_left_command,
  output logic [23:0]  out_right_command
);

  `include "assert_macros.svh"

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic ld5;
  logic free1, free2, free3, free4;
  lane_res_t left_r, right_r;

  // Each stage takes a new transaction when it is empty or its own
  // transaction moves on in the same cycle.
  assign ld5    = v4_r && (!vo_r || out_ready);
  assign free4  = !v4_r || ld5;
  assign adv.s4 = v3_r && free4;
  assign free3  = !v3_r || adv.s4;
  assign adv.s3 = v2_r && free3;
  assign free2  = !v2_r || adv.s3;
  assign adv.s2 = v1_r && free2;
  assign free1  = !v1_r || adv.s2;
  assign adv.s1 = in_valid && free1;
  assign in_ready = free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= adv.s1 || (v1_r && !adv.s2);
      v2_r <= adv.s2 || (v2_r && !adv.s3);
      v3_r <= adv.s3 || (v3_r && !adv.s4);
      v4_r <= adv.s4 || (v4_r && !ld5);
      vo_r <= ld5 || (vo_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      left_r  <= left_res;
      right_r <= right_res;
    end
  end

  assign out_valid         = vo_r;
  assign out_left_pulse    = left_r.pulse;
  assign out_left_reverse  = left_r.reverse;
  assign out_left_command  = left_r.command;
  assign out_right_pulse   = right_r.pulse;
  assign out_right_reverse = right_r.reverse;
  assign out_right_command = right_r.command;

  `ASSERT_IMP(a_empty_accepts, clk, rst_n, !v1_r && !v2_r && !v3_r && !v4_r, in_ready,
    "empty pipeline refuses a transaction")
  `ASSERT_IMP(a_finished_moves, clk, rst_n, v4_r && !vo_r, ld5,
    "finished transaction not moved into empty output register")
  `ASSERT_NXT(a_out_refill, clk, rst_n, vo_r && out_ready && v4_r, out_valid,
    "output register not refilled after a completed transaction")

endmodule

// ----- rtl/dual_wheel_pid_motor_drive_unit.sv -----
// Dual-wheel PID speed controller with PWM clamp.
// Input channel (in_valid/in_ready): one transaction per control tick with the
// encoder counts and target speeds of both wheels. Result channel
// (out_valid/out_ready): PWM pulse, direction and unclamped command per wheel.
// Gains, dead offset and PWM limit are written over the APB-style port at
// byte addresses 0x00..0x1c; write them only while no transaction is in flight.
// Two identical wheel lanes run side by side, each a four-stage pipeline
// (error, gain products, integral update, truncated command); a shared output
// register merges both lanes into one result.
// Each result passes through the four lane stages and then the output register.
// Throughput: one transaction per cycle while out_ready keeps the output
// register draining; the integral accumulate in each lane keeps that rate.
// Reset (rst_n low, synchronous) restores the default gains, dead offset and
// PWM limit, clears the integrals and previous errors and empties every pipeline stage.
// When the receiver stalls, the output register holds its result and stages
// behind it keep filling; in_ready drops only once all four stages are full.
module dual_wheel_pid_motor_drive_unit
  import dwpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_left_count,
  input  logic signed [15:0] in_right_count,
  input  logic signed [15:0] in_left_target,
  input  logic signed [15:0] in_right_target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_left_pulse,
  output logic               out_left_reverse,
  output logic [9:0]         out_right_pulse,
  output logic               out_right_reverse,
  output logic signed [23:0] out_left_command,
  output logic signed [23:0] out_right_command
);

  logic [15:0] left_kp_r, left_ki_r, left_kd_r;
  logic [15:0] right_kp_r, right_ki_r, right_kd_r;
  logic [7:0]  dead_offset_r;
  logic [9:0]  drive_cap_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic        wr_en;
  adv_t        adv;
  lane_res_t   left_res, right_res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_kp_r     <= KP_RESET;
      left_ki_r     <= KI_RESET;
      left_kd_r     <= KD_RESET;
      right_kp_r    <= KP_RESET;
      right_ki_r    <= KI_RESET;
      right_kd_r    <= KD_RESET;
      dead_offset_r <= DEAD_RESET;
      drive_cap_r   <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_KP:     left_kp_r     <= pwdata[15:0];
        REG_LEFT_KI:     left_ki_r     <= pwdata[15:0];
        REG_LEFT_KD:     left_kd_r     <= pwdata[15:0];
        REG_RIGHT_KP:    right_kp_r    <= pwdata[15:0];
        REG_RIGHT_KI:    right_ki_r    <= pwdata[15:0];
        REG_RIGHT_KD:    right_kd_r    <= pwdata[15:0];
        REG_DEAD_OFFSET: dead_offset_r <= pwdata[7:0];
        REG_DRIVE_CAP:   drive_cap_r   <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_KP:     prdata = {16'd0, left_kp_r};
      REG_LEFT_KI:     prdata = {16'd0, left_ki_r};
      REG_LEFT_KD:     prdata = {16'd0, left_kd_r};
      REG_RIGHT_KP:    prdata = {16'd0, right_kp_r};
      REG_RIGHT_KI:    prdata = {16'd0, right_ki_r};
      REG_RIGHT_KD:    prdata = {16'd0, right_kd_r};
      REG_DEAD_OFFSET: prdata = {24'd0, dead_offset_r};
      REG_DRIVE_CAP:   prdata = {22'd0, drive_cap_r};
    endcase
  end

  dwpid_lane u_left_lane (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .count       (in_left_count),
    .target      (in_left_target),
    .kp          (left_kp_r),
    .ki          (left_ki_r),
    .kd          (left_kd_r),
    .dead_offset (dead_offset_r),
    .drive_cap   (drive_cap_r),
    .res         (left_res)
  );

  dwpid_lane u_right_lane (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .count       (in_right_count),
    .target      (in_right_target),
    .kp          (right_kp_r),
    .ki          (right_ki_r),
    .kd          (right_kd_r),
    .dead_offset (dead_offset_r),
    .drive_cap   (drive_cap_r),
    .res         (right_res)
  );

  dwpid_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .adv               (adv),
    .left_res          (left_res),
    .right_res         (right_res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_pulse    (out_left_pulse),
    .out_left_reverse  (out_left_reverse),
    .out_right_pulse   (out_right_pulse),
    .out_right_reverse (out_right_reverse),
    .out_left_command  (out_left_command),
    .out_right_command (out_right_command)
  );

endmodule
